[rtl/wps_pkg.sv]
// Shared types, grid constants and the coordinate clamp for the waypoint path stepper.
// No dependencies.
package wps_pkg;

  localparam int CoordW   = 5;
  localparam int GridRows = 32;
  localparam int GridCols = 32;

  typedef logic [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t waypoint_row;
    coord_t waypoint_col;
    logic   last_point;
  } wps_in_t;

  typedef struct packed {
    coord_t cell_row;
    coord_t cell_col;
    logic   final_res;
  } wps_out_t;

  // one classified request handed from the front to the back
  typedef struct packed {
    coord_t tgt_row;
    coord_t tgt_col;
    logic   last;
  } wps_cmd_t;

  // off-grid coordinates saturate to the last row or column
  function automatic coord_t clamp_coord(input coord_t v, input int limit);
    if (int'(v) >= limit) begin
      return CoordW'(limit - 1);
    end
    return v;
  endfunction

endpackage

[rtl/waypoint_path_stepper.sv]
// Waypoint path stepper: turns a stream of grid waypoints into the cells of a
// 4-connected path between them on the 32x32 grid. Each request enters the back
// end, whose single cell stepper then emits one segment cell per cycle while
// the output is not stalled, and closes the request with a step that also emits
// the endpoint of a last waypoint. A two-entry queue lets the input keep taking
// requests while a segment is being walked.
// Depends on wps_pkg, wps_front, wps_queue, wps_back.
module waypoint_path_stepper import wps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  wps_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output wps_out_t out_data
);

  logic     f_valid;
  logic     f_ready;
  wps_cmd_t f_data;
  logic     q_valid;
  logic     q_ready;
  wps_cmd_t q_data;

  wps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd_data  (f_data)
  );

  wps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  wps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd_data  (q_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/wps_front.sv]
// Front end: takes waypoint requests, clamps them onto the grid and registers them.
// Depends on wps_pkg.
module wps_front import wps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  wps_in_t  in_data,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output wps_cmd_t cmd_data
);

  logic     valid_r;
  logic     valid_nxt;
  wps_cmd_t cmd_r;

  assign in_stall  = valid_r && !cmd_ready;
  assign cmd_valid = valid_r;
  assign cmd_data  = cmd_r;

  always_comb begin
    valid_nxt = valid_r;
    if (valid_r && cmd_ready) begin
      valid_nxt = 1'b0;
    end
    if (in_valid && !in_stall) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_r.tgt_row <= clamp_coord(in_data.waypoint_row, GridRows);
      cmd_r.tgt_col <= clamp_coord(in_data.waypoint_col, GridCols);
      cmd_r.last    <= in_data.last_point;
    end
  end

endmodule

[rtl/wps_queue.sv]
// Two-entry request queue between front and back; head always sits in slot 0.
// Depends on wps_pkg.
module wps_queue import wps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  wps_cmd_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output wps_cmd_t pop_data
);

  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  wps_cmd_t   slot0_r;
  wps_cmd_t   slot1_r;
  logic       push;
  logic       pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = slot0_r;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      slot0_r <= slot1_r;
      if (push && cnt_r == 2'd1) begin
        slot0_r <= push_data;
      end else if (push) begin
        slot1_r <= push_data;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        slot0_r <= push_data;
      end else begin
        slot1_r <= push_data;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue count out of range");

  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !pop) |=> cnt_r == 2'd2)
    else $error("full queue lost an entry without a pop");

endmodule

[rtl/wps_back.sv]
// Back end: walks each segment one cell per cycle while the output is not stalled, and drives the result register.
// Depends on wps_pkg.
module wps_back import wps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  input  wps_cmd_t cmd_data,
  output logic     out_valid,
  input  logic     out_stall,
  output wps_out_t out_data
);

  logic     busy_r;
  logic     busy_nxt;
  logic     have_start_r;
  logic     have_start_nxt;
  coord_t   cur_row_r;
  coord_t   cur_row_nxt;
  coord_t   cur_col_r;
  coord_t   cur_col_nxt;
  wps_cmd_t cmd_r;
  logic     out_valid_r;
  logic     out_valid_nxt;
  wps_out_t out_data_r;
  wps_out_t out_data_nxt;

  logic     can_out;
  logic     at_target;
  logic     step_fire;
  logic     finish_fire;
  coord_t   dr;
  coord_t   dc;

  assign can_out   = !out_valid_r || !out_stall;
  assign at_target = (cur_row_r == cmd_r.tgt_row) && (cur_col_r == cmd_r.tgt_col);
  assign step_fire   = busy_r && can_out && have_start_r && !at_target;
  assign finish_fire = busy_r && can_out && !(have_start_r && !at_target);
  assign cmd_ready = !busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign dr = (cmd_r.tgt_row > cur_row_r) ? cmd_r.tgt_row - cur_row_r
                                          : cur_row_r - cmd_r.tgt_row;
  assign dc = (cmd_r.tgt_col > cur_col_r) ? cmd_r.tgt_col - cur_col_r
                                          : cur_col_r - cmd_r.tgt_col;

  always_comb begin
    busy_nxt       = busy_r;
    have_start_nxt = have_start_r;
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    if (!busy_r && cmd_valid) begin
      busy_nxt = 1'b1;
    end
    if (step_fire) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.cell_row  = cur_row_r;
      out_data_nxt.cell_col  = cur_col_r;
      out_data_nxt.final_res = 1'b0;
      // ties go along the column
      if (dr <= dc) begin
        cur_col_nxt = (cmd_r.tgt_col < cur_col_r) ? cur_col_r - 1'b1 : cur_col_r + 1'b1;
      end else begin
        cur_row_nxt = (cmd_r.tgt_row < cur_row_r) ? cur_row_r - 1'b1 : cur_row_r + 1'b1;
      end
    end else if (finish_fire) begin
      busy_nxt       = 1'b0;
      cur_row_nxt    = cmd_r.tgt_row;
      cur_col_nxt    = cmd_r.tgt_col;
      have_start_nxt = !cmd_r.last;
      if (cmd_r.last) begin
        out_valid_nxt          = 1'b1;
        out_data_nxt.cell_row  = cmd_r.tgt_row;
        out_data_nxt.cell_col  = cmd_r.tgt_col;
        out_data_nxt.final_res = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      have_start_r <= 1'b0;
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      have_start_r <= have_start_nxt;
      cur_row_r    <= cur_row_nxt;
      cur_col_r    <= cur_col_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (!busy_r && cmd_valid) begin
      cmd_r <= cmd_data;
    end
  end

  a_one_axis: assert property (@(posedge clk) disable iff (!rst_n)
    step_fire |=> ((cur_row_r != $past(cur_row_r)) != (cur_col_r != $past(cur_col_r))))
    else $error("segment step did not move along exactly one axis");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (finish_fire && cmd_r.last) |=> (!have_start_r && out_valid_r && out_data_r.final_res))
    else $error("route end did not emit final cell and drop the start");

  a_step_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
    step_fire |-> have_start_r)
    else $error("segment cell emitted with no start held");

endmodule
